@@ rtl/rama_pkg.sv @@
// ----------------------------------------------------------------------------
// rama_pkg
// Shared types, widths and range tables for the ranged ammeter averager.
// ----------------------------------------------------------------------------
package rama_pkg;

    localparam int WINDOW      = 8;
    localparam int PTR_W       = $clog2(WINDOW);
    localparam int SAMPLE_W    = 10;
    localparam int SUM_W       = 13;
    localparam int SCALE_K_W   = 13;
    localparam int PROD_W      = SUM_W + SCALE_K_W;
    localparam int SCALE_SHIFT = 13;
    localparam int V_W         = PROD_W - SCALE_SHIFT;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 22;
    localparam int WHOLE_W     = 6;
    localparam int HUND_W      = 7;
    localparam int AMPS_W      = 6;
    localparam int RANGE_W     = 2;
    localparam int MODE_W      = 2;

    // floor(v / 100) == (v * RECIP_100) >> RECIP_SHIFT for v < 8192
    localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
    localparam logic [HUND_W-1:0]  PCT       = 7'd100;

    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [RANGE_W-1:0] RANGE_10A = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_20A = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_40A = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_50A = 2'd3;

    typedef struct packed {
        logic sample_en;
        logic step_en;
        logic mul_en;
        logic div_en;
        logic load_en;
    } rama_cmd_t;

    function automatic logic [AMPS_W-1:0] scale_amps(input logic [RANGE_W-1:0] rng);
        logic [AMPS_W-1:0] amps;
        unique case (rng)
            RANGE_10A: amps = 6'd10;
            RANGE_20A: amps = 6'd20;
            RANGE_40A: amps = 6'd40;
            RANGE_50A: amps = 6'd50;
            default:   amps = 6'd10;
        endcase
        return amps;
    endfunction

    // full scale times 100
    function automatic logic [SCALE_K_W-1:0] scale_x100(input logic [RANGE_W-1:0] rng);
        logic [SCALE_K_W-1:0] k;
        unique case (rng)
            RANGE_10A: k = 13'd1000;
            RANGE_20A: k = 13'd2000;
            RANGE_40A: k = 13'd4000;
            RANGE_50A: k = 13'd5000;
            default:   k = 13'd1000;
        endcase
        return k;
    endfunction

    // 90 percent of full scale, in hundredths of an amp
    function automatic logic [V_W-1:0] near_limit(input logic [RANGE_W-1:0] rng);
        logic [V_W-1:0] lim;
        unique case (rng)
            RANGE_10A: lim = 13'd900;
            RANGE_20A: lim = 13'd1800;
            RANGE_40A: lim = 13'd3600;
            RANGE_50A: lim = 13'd4500;
            default:   lim = 13'd900;
        endcase
        return lim;
    endfunction

endpackage

@@ rtl/rama_ctrl.sv @@
// ----------------------------------------------------------------------------
// rama_ctrl
// Sequencer: takes input words, steps a read through multiply, divide and
// output load, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rama_ctrl
    import rama_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    output logic              out_valid,
    input  logic              out_stall,
    output rama_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_accept;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (mode)
                        MODE_SAMPLE: cmd.sample_en = 1'b1;
                        MODE_STEP:   cmd.step_en   = 1'b1;
                        MODE_READ:   state_next    = ST_MUL;
                        default:     ;
                    endcase
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.load_en    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |-> out_free)
        else $error("output loaded over a pending word");

    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == MODE_READ) |=> ##1 cmd.div_en)
        else $error("read did not reach the divide step");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

endmodule

@@ rtl/rama_dp.sv @@
// ----------------------------------------------------------------------------
// rama_dp
// Datapath: sample ring with running sum, range register, scale multiply,
// reciprocal divide by 100 and the output register.
// ----------------------------------------------------------------------------
module rama_dp
    import rama_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rama_cmd_t           cmd,
    input  logic [SAMPLE_W-1:0] adc_sample,
    output logic [WHOLE_W-1:0]  current_whole_amps,
    output logic [HUND_W-1:0]   current_hundredths,
    output logic [AMPS_W-1:0]   full_scale_amps,
    output logic                near_full_scale,
    output logic [RANGE_W-1:0]  input_channel
);

    logic [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic [PTR_W-1:0]    ptr_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [RANGE_W-1:0]  range_reg;

    logic [PROD_W-1:0]          prod_reg;
    logic [V_W-1:0]             v_reg;
    logic [WHOLE_W-1:0]         quot_reg;
    logic [V_W-1:0]             v_next;
    logic [V_W+RECIP_W-1:0]     recip_prod;
    logic [V_W-1:0]             rem_full;

    logic [WHOLE_W-1:0] whole_reg;
    logic [HUND_W-1:0]  hund_reg;
    logic [AMPS_W-1:0]  amps_reg;
    logic               near_reg;
    logic [RANGE_W-1:0] chan_reg;

    // drop the oldest sample, add the new one
    assign sum_next = sum_reg - SUM_W'(ring_reg[ptr_reg]) + SUM_W'(adc_sample);

    assign v_next     = prod_reg[PROD_W-1:SCALE_SHIFT];
    assign recip_prod = v_next * RECIP_100;
    assign rem_full   = v_reg - V_W'(quot_reg) * V_W'(PCT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            ptr_reg   <= '0;
            sum_reg   <= '0;
            range_reg <= RANGE_10A;
        end
        else
        begin
            if (cmd.sample_en)
            begin
                ring_reg[ptr_reg] <= adc_sample;
                ptr_reg           <= ptr_reg + 1'b1;
                sum_reg           <= sum_next;
            end
            if (cmd.step_en)
            begin
                range_reg <= range_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= sum_reg * scale_x100(range_reg);
        end
        if (cmd.div_en)
        begin
            v_reg    <= v_next;
            quot_reg <= recip_prod[RECIP_SHIFT +: WHOLE_W];
        end
        if (cmd.load_en)
        begin
            whole_reg <= quot_reg;
            hund_reg  <= rem_full[HUND_W-1:0];
            amps_reg  <= scale_amps(range_reg);
            near_reg  <= (v_reg >= near_limit(range_reg));
            chan_reg  <= range_reg;
        end
    end

    assign current_whole_amps = whole_reg;
    assign current_hundredths = hund_reg;
    assign full_scale_amps    = amps_reg;
    assign near_full_scale    = near_reg;
    assign input_channel      = chan_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |-> (rem_full < V_W'(PCT)))
        else $error("remainder of divide by 100 out of range");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_en |-> (quot_reg < WHOLE_W'(50)))
        else $error("whole amps beyond largest full scale");

endmodule

@@ rtl/ranged_ammeter_moving_average_unit.sv @@
// ----------------------------------------------------------------------------
// ranged_ammeter_moving_average_unit
// Ammeter front end: eight-sample moving sum with switchable full scale.
// ----------------------------------------------------------------------------
// A sample word or a range step word is taken while the sequencer is idle,
// and the next word may follow in the next cycle. A read word is accepted,
// then passes through the scale multiplier, the reciprocal multiply that
// divides by 100 and the load of the output register; the load waits while
// an earlier readout is still stalled. Input stays stalled from the read
// until the output register is loaded. Mode 3 words are taken and dropped.
// Readouts come out as whole amps plus hundredths, with the full scale, the
// matching channel select and a flag at 90 percent of scale.
// ----------------------------------------------------------------------------
module ranged_ammeter_moving_average_unit
    import rama_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [SAMPLE_W-1:0] adc_sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WHOLE_W-1:0]  current_whole_amps,
    output logic [HUND_W-1:0]   current_hundredths,
    output logic [AMPS_W-1:0]   full_scale_amps,
    output logic                near_full_scale,
    output logic [RANGE_W-1:0]  input_channel
);

    rama_cmd_t cmd;

    rama_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    rama_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .adc_sample         (adc_sample),
        .current_whole_amps (current_whole_amps),
        .current_hundredths (current_hundredths),
        .full_scale_amps    (full_scale_amps),
        .near_full_scale    (near_full_scale),
        .input_channel      (input_channel)
    );

endmodule
